// ===== hdl/sfkh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfkh_pkg
// Shared types, constants and fold functions for the symmetric flow key hash.
// ----------------------------------------------------------------------------
package sfkh_pkg;

  localparam int ADDR_W = 64;
  localparam int PORT_W = 16;
  localparam int PROTO_W = 8;
  localparam int HASH_W = 64;
  localparam int WORD_W = 32;

  // value slots: family, four source words, four destination words,
  // source port, destination port, protocol
  localparam int NUM_SLOTS = 12;
  localparam int FOLDS_PER_STAGE = 2;
  localparam int NUM_STAGES = NUM_SLOTS / FOLDS_PER_STAGE;

  localparam logic [HASH_W-1:0] GOLDEN_ADD = 64'h0000_0000_9e37_79b9;

  typedef struct packed {
    logic [HASH_W-1:0]                 h;
    logic [NUM_SLOTS-1:0][WORD_W-1:0]  vals;
    logic [NUM_SLOTS-1:0]              act;
    logic                              swapped;
  } stage_t;

  function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h,
                                             input logic [WORD_W-1:0] v);
    logic [HASH_W-1:0] sum;
    sum = {{(HASH_W-WORD_W){1'b0}}, v} + GOLDEN_ADD + (h << 6) + (h >> 2);
    return h ^ sum;
  endfunction

endpackage

// ===== hdl/sfkh_if.sv =====
// ----------------------------------------------------------------------------
// sfkh_if
// Valid/ready channels for the flow key and the resulting hash.
// ----------------------------------------------------------------------------
interface sfkh_key_if;
  import sfkh_pkg::*;

  logic               valid;
  logic               ready;
  logic               addr_is_v6;
  logic [ADDR_W-1:0]  src_addr_hi;
  logic [ADDR_W-1:0]  src_addr_lo;
  logic [ADDR_W-1:0]  dst_addr_hi;
  logic [ADDR_W-1:0]  dst_addr_lo;
  logic [PORT_W-1:0]  src_l4_port;
  logic [PORT_W-1:0]  dst_l4_port;
  logic [PROTO_W-1:0] proto_num;

  modport source (output valid, addr_is_v6, src_addr_hi, src_addr_lo, dst_addr_hi,
                  dst_addr_lo, src_l4_port, dst_l4_port, proto_num, input ready);
  modport sink   (input valid, addr_is_v6, src_addr_hi, src_addr_lo, dst_addr_hi,
                  dst_addr_lo, src_l4_port, dst_l4_port, proto_num, output ready);
endinterface

interface sfkh_hash_if;
  import sfkh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] flow_hash;
  logic              was_swapped;

  modport source (output valid, flow_hash, was_swapped, input ready);
  modport sink   (input valid, flow_hash, was_swapped, output ready);
endinterface

// ===== hdl/sfkh_canon.sv =====
// ----------------------------------------------------------------------------
// sfkh_canon
// Orders the endpoints and registers the canonical key as a list of fold values.
// ----------------------------------------------------------------------------
module sfkh_canon (
  input  logic            clk,
  input  logic            rst,
  sfkh_key_if.sink        key,
  input  logic            down_ready,
  output logic            out_valid,
  output sfkh_pkg::stage_t out_data
);
  import sfkh_pkg::*;

  logic                v6;
  logic [ADDR_W-1:0]   sh, sl, dh, dl;
  logic [ADDR_W-1:0]   csh, csl, cdh, cdl;
  logic [PORT_W-1:0]   csp, cdp;
  logic                less, equal, keep;
  logic                adv;
  stage_t              data_next;

  assign v6 = key.addr_is_v6;
  assign sh = v6 ? key.src_addr_hi : '0;
  assign dh = v6 ? key.dst_addr_hi : '0;
  assign sl = v6 ? key.src_addr_lo : {{(ADDR_W-WORD_W){1'b0}}, key.src_addr_lo[WORD_W-1:0]};
  assign dl = v6 ? key.dst_addr_lo : {{(ADDR_W-WORD_W){1'b0}}, key.dst_addr_lo[WORD_W-1:0]};

  assign less  = {sh, sl} < {dh, dl};
  assign equal = {sh, sl} == {dh, dl};
  assign keep  = less || (equal && (key.src_l4_port <= key.dst_l4_port));

  assign csh = keep ? sh : dh;
  assign csl = keep ? sl : dl;
  assign cdh = keep ? dh : sh;
  assign cdl = keep ? dl : sl;
  assign csp = keep ? key.src_l4_port : key.dst_l4_port;
  assign cdp = keep ? key.dst_l4_port : key.src_l4_port;

  always_comb begin
    data_next.h        = '0;
    data_next.swapped  = !keep;
    data_next.vals[0]  = {{(WORD_W-1){1'b0}}, v6};
    data_next.vals[1]  = v6 ? bswap32(csh[63:32]) : csl[WORD_W-1:0];
    data_next.vals[2]  = bswap32(csh[31:0]);
    data_next.vals[3]  = bswap32(csl[63:32]);
    data_next.vals[4]  = bswap32(csl[31:0]);
    data_next.vals[5]  = v6 ? bswap32(cdh[63:32]) : cdl[WORD_W-1:0];
    data_next.vals[6]  = bswap32(cdh[31:0]);
    data_next.vals[7]  = bswap32(cdl[63:32]);
    data_next.vals[8]  = bswap32(cdl[31:0]);
    data_next.vals[9]  = {{(WORD_W-PORT_W){1'b0}}, csp};
    data_next.vals[10] = {{(WORD_W-PORT_W){1'b0}}, cdp};
    data_next.vals[11] = {{(WORD_W-PROTO_W){1'b0}}, key.proto_num};
    data_next.act      = '1;
    data_next.act[2]   = v6;
    data_next.act[3]   = v6;
    data_next.act[4]   = v6;
    data_next.act[6]   = v6;
    data_next.act[7]   = v6;
    data_next.act[8]   = v6;
  end

  assign adv       = !out_valid || down_ready;
  assign key.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && key.valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/sfkh_stage.sv =====
// ----------------------------------------------------------------------------
// sfkh_stage
// One pipeline stage: folds the two leading values into the hash, skipping inactive ones.
// ----------------------------------------------------------------------------
module sfkh_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sfkh_pkg::stage_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output sfkh_pkg::stage_t out_data,
  input  logic             down_ready
);
  import sfkh_pkg::*;

  stage_t data_next;

  always_comb begin
    logic [HASH_W-1:0] h;
    h = in_data.h;
    for (int i = 0; i < FOLDS_PER_STAGE; i++) begin
      if (in_data.act[i]) begin
        h = fold(h, in_data.vals[i]);
      end
    end
    data_next.h       = h;
    data_next.vals    = in_data.vals >> (FOLDS_PER_STAGE * WORD_W);
    data_next.act     = in_data.act >> FOLDS_PER_STAGE;
    data_next.swapped = in_data.swapped;
  end

  assign in_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/symmetric_flow_key_hash.sv =====
// ----------------------------------------------------------------------------
// symmetric_flow_key_hash
// Direction-independent 64-bit hash of a flow five-tuple.
//
//   channel  dir  carries
//   key      in   addr_is_v6, src/dst addresses, src/dst ports, proto_num
//   hash     out  flow_hash, was_swapped
//
// One key per cycle sustained while hash.ready stays high; the path is the canonical
// key register, then six stages of two hash folds each.
// The fold chain of up to twelve dependent 64-bit folds sets the depth.
// Reset clears all stage valid bits; no result appears until a key arrives.
// A stall on hash fills bubbles first, then holds key.ready low.
// ----------------------------------------------------------------------------
module symmetric_flow_key_hash (
  input  logic       clk,
  input  logic       rst,
  sfkh_key_if.sink   key,
  sfkh_hash_if.source hash
);
  import sfkh_pkg::*;

  logic   [NUM_STAGES:0] vld;
  logic   [NUM_STAGES:0] rdy;
  stage_t                data [NUM_STAGES+1];

  sfkh_canon u_canon (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .down_ready (rdy[0]),
    .out_valid  (vld[0]),
    .out_data   (data[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    sfkh_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (vld[k]),
      .in_data    (data[k]),
      .in_ready   (rdy[k]),
      .out_valid  (vld[k+1]),
      .out_data   (data[k+1]),
      .down_ready (rdy[k+1])
    );
  end

  assign rdy[NUM_STAGES] = hash.ready;
  assign hash.valid       = vld[NUM_STAGES];
  assign hash.flow_hash   = data[NUM_STAGES].h;
  assign hash.was_swapped = data[NUM_STAGES].swapped;

endmodule

// ===== hdl/sfkh_check.sv =====
// ----------------------------------------------------------------------------
// sfkh_check
// Port-level checks on the flow key hash, bound to the top level.
// ----------------------------------------------------------------------------
module sfkh_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      key_valid,
  input logic                      key_ready,
  input logic                      hash_valid,
  input logic                      hash_ready,
  input logic [sfkh_pkg::HASH_W-1:0] flow_hash,
  input logic                      was_swapped
);
  import sfkh_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !hash_valid)
    else $error("hash valid right after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (hash_ready || !hash_valid) |-> key_ready)
    else $error("key not taken while output side is free");

  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({key_ready, hash_valid}))
    else $error("handshake signal unknown");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (hash_valid && !hash_ready) |=> hash_valid && $stable(flow_hash) && $stable(was_swapped))
    else $error("stalled result changed");

endmodule

bind symmetric_flow_key_hash sfkh_check u_check (
  .clk         (clk),
  .rst         (rst),
  .key_valid   (key.valid),
  .key_ready   (key.ready),
  .hash_valid  (hash.valid),
  .hash_ready  (hash.ready),
  .flow_hash   (hash.flow_hash),
  .was_swapped (hash.was_swapped)
);
